### hdl/doss_pkg.sv
// doss_pkg: shared types and constants of the dual orbit step sequencer
// gate bit positions, option bits, register indexes, knob maps, clock modes
// no dependencies
`default_nettype none

package doss_pkg;

	localparam int GATE_W = 10;

	localparam int GATE_RUN     = 0;
	localparam int GATE_LEAP    = 1;
	localparam int GATE_MODE_A  = 2;
	localparam int GATE_SPAN_A  = 4;
	localparam int GATE_GLOBAL  = 6;
	localparam int GATE_LOCAL_A = 7;
	localparam int GATE_RESET   = 9;

	localparam int OPT_RUN_RESET = 0;
	localparam int OPT_QUANT     = 1;
	localparam int OPT_COPY      = 2;

	localparam logic [2:0] REG_KNOB_0  = 3'd0;
	localparam logic [2:0] REG_KNOB_1  = 3'd1;
	localparam logic [2:0] REG_KNOB_2  = 3'd2;
	localparam logic [2:0] REG_KNOB_3  = 3'd3;
	localparam logic [2:0] REG_HOLDOFF = 3'd4;
	localparam logic [2:0] REG_OPTIONS = 3'd5;

	localparam logic [1:0] CLK_GLOBAL = 2'd0;
	localparam logic [1:0] CLK_LOCAL  = 2'd1;
	localparam logic [1:0] CLK_BOTH   = 2'd2;

	localparam logic [15:0] HOLDOFF_RESET = 16'd44;
	localparam logic [2:0]  OPTIONS_RESET = 3'd2;
	localparam logic [1:0]  SPAN_RESET    = 2'd1;

	localparam int VOLT_W = 19;

	// step position to knob index, one row per sequencer
	localparam logic [3:0] KNOB_MAP [2][16] = '{
		'{4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7,
		  4'd0, 4'd8, 4'd9, 4'd10, 4'd11, 4'd12, 4'd13, 4'd14},
		'{4'd0, 4'd8, 4'd9, 4'd10, 4'd11, 4'd12, 4'd13, 4'd14,
		  4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7}
	};

	typedef struct packed {
		logic [1:0] span;
		logic       quant;
	} volt_ctl_t;

endpackage

`default_nettype wire

### hdl/doss_volt.sv
// doss_volt: knob value to control voltage, linear or semitone quantized
// uses doss_pkg (volt_ctl_t, VOLT_W)
`default_nettype none

module doss_volt #(
	parameter int KNOB_BITS = 12
) (
	input  logic [KNOB_BITS-1:0]              knob,
	input  doss_pkg::volt_ctl_t               ctl,
	output logic signed [doss_pkg::VOLT_W-1:0] voltage
);
	import doss_pkg::*;

	localparam int PW = KNOB_BITS + 3;
	localparam int UW = PW + 2 + 14;
	localparam int QW = KNOB_BITS + 7;
	localparam int MW = VOLT_W - 1;

	logic [2:0]          mul;
	logic [PW-1:0]       prod;
	logic [UW-1:0]       lin_wide;
	logic [MW-1:0]       lin_mag;
	logic [MW-1:0]       offset;
	logic signed [VOLT_W-1:0] lin_volt;
	logic [QW-1:0]       qa;
	logic [QW-1:0]       qb;
	logic [QW-1:0]       qmag;
	logic [QW-1:0]       qround;
	logic [5:0]          semis;
	logic [MW-1:0]       qvolt_mag;
	logic signed [VOLT_W-1:0] qvolt;

	always_comb begin
		mul = {ctl.span, 1'b1};
		prod = PW'(knob) * PW'(mul);

		// k * (2r+1) * 49152 / 2^KNOB_BITS, with 49152 = 3 << 14
		lin_wide = (UW'(prod) * UW'(3)) << 14;
		lin_mag = MW'(lin_wide >> KNOB_BITS);
		offset = MW'(ctl.span) * MW'(49152);
		lin_volt = signed'({1'b0, lin_mag}) - signed'({1'b0, offset});

		// semitones, rounded half away from zero
		qa = QW'(prod) * QW'(12);
		qb = QW'(5'(ctl.span) * 5'd12) << KNOB_BITS;
		qmag = (qa >= qb) ? (qa - qb) : (qb - qa);
		qround = (qmag + (QW'(1) << (KNOB_BITS - 1))) >> KNOB_BITS;
		semis = 6'(qround);
		qvolt_mag = MW'({semis, 12'b0});
		qvolt = (qa >= qb) ? signed'({1'b0, qvolt_mag}) : -signed'({1'b0, qvolt_mag});

		voltage = ctl.quant ? qvolt : lin_volt;
	end

endmodule

`default_nettype wire

### hdl/dual_orbit_step_sequencer_core.sv
// dual_orbit_step_sequencer_core: top level, edge detection, step state, output register
// uses doss_pkg and doss_volt
//
//  channel  | handshake                     | payload
//  request  | item_valid / item_ready       | gate_levels, jump_chance, random_a, random_b
//  result   | result_valid / result_ready   | voltage_a/b, position_a/b, status fields
//  config   | cfg_write                     | cfg_index, cfg_data
//
// one request per cycle while result_ready holds; via input, second and result registers
// the step state loop: input register, state update, second register
// voltage scaling sits between the second register and the result register
// arst_n resets all control and step state to fixed values; no clearing pass
// ready chains back through the stages, so bubbles are filled while the result waits
`default_nettype none

module dual_orbit_step_sequencer_core #(
	parameter int KNOB_BITS = 12
) (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        cfg_write,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_data,

	input  logic        item_valid,
	output logic        item_ready,
	input  logic [9:0]  gate_levels,
	input  logic [16:0] jump_chance,
	input  logic [15:0] random_a,
	input  logic [15:0] random_b,

	output logic        result_valid,
	input  logic        result_ready,
	output logic signed [18:0] voltage_a,
	output logic signed [18:0] voltage_b,
	output logic [3:0]  position_a,
	output logic [3:0]  position_b,
	output logic        run_state,
	output logic        leap_state,
	output logic [1:0]  clock_mode_a,
	output logic [1:0]  clock_mode_b,
	output logic [1:0]  octave_span_a,
	output logic [1:0]  octave_span_b
);
	import doss_pkg::*;

	// configuration
	logic [63:0] bank_q [4];
	logic [15:0] holdoff_ticks_q;
	logic [2:0]  opt_q;

	// step state
	logic             run_q;
	logic             leap_q;
	logic [3:0]       pos_q [2];
	logic [1:0]       cm_q [2];
	logic [1:0]       span_q [2];
	logic [15:0]      hold_q;
	logic [GATE_W-1:0] prev_q;

	// stage 1: request register
	logic              v_s1;
	logic [GATE_W-1:0] lv_s1;
	logic [16:0]       chance_s1;
	logic [15:0]       rnd_s1 [2];

	// stage 2: knobs and status
	logic                 v_s2;
	logic [KNOB_BITS-1:0] k_s2 [2];
	volt_ctl_t            ctl_s2 [2];
	logic [3:0]           pos_s2 [2];
	logic [1:0]           cm_s2 [2];
	logic                 run_s2;
	logic                 leap_s2;

	// result register
	logic                    res_valid_q;
	logic signed [VOLT_W-1:0] volt_q [2];
	logic [3:0]              pos_out_q [2];
	logic [1:0]              cm_out_q [2];
	logic [1:0]              span_out_q [2];
	logic                    run_out_q;
	logic                    leap_out_q;

	logic adv_out;
	logic adv_s2;
	logic adv_s1;

	// next-state logic
	logic [GATE_W-1:0]    rise;
	logic                 run_n;
	logic                 leap_n;
	logic [15:0]          hold;
	logic [15:0]          hold_n;
	logic [3:0]           pos [2];
	logic [1:0]           cm_n [2];
	logic [1:0]           span_n [2];
	logic                 fire [2];
	logic                 jump [2];
	logic [GATE_W-1:0]    prev_n;
	logic [3:0]           kidx [2];
	logic [15:0]          slot [2];
	logic signed [VOLT_W-1:0] volt [2];

	function automatic logic [1:0] cycle3(input logic [1:0] v);
		return v[1] ? 2'd0 : v + 2'd1;
	endfunction

	assign adv_out = !res_valid_q || result_ready;
	assign adv_s2 = !v_s2 || adv_out;
	assign adv_s1 = !v_s1 || adv_s2;
	assign item_ready = adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int b = 0; b < 4; b++)
				bank_q[b] <= '0;
			holdoff_ticks_q <= HOLDOFF_RESET;
			opt_q <= OPTIONS_RESET;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_KNOB_0: bank_q[0] <= cfg_data;
				REG_KNOB_1: bank_q[1] <= cfg_data;
				REG_KNOB_2: bank_q[2] <= cfg_data;
				REG_KNOB_3: bank_q[3] <= cfg_data;
				REG_HOLDOFF: holdoff_ticks_q <= cfg_data[15:0];
				REG_OPTIONS: opt_q <= cfg_data[2:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		rise = lv_s1 & ~prev_q;
		run_n = run_q ^ rise[GATE_RUN];
		leap_n = leap_q ^ rise[GATE_LEAP];
		hold = hold_q;
		pos = pos_q;
		if (rise[GATE_RUN] && run_n) begin
			hold = holdoff_ticks_q;
			if (opt_q[OPT_RUN_RESET]) begin
				pos[0] = 4'd0;
				pos[1] = 4'd0;
			end
		end
		for (int i = 0; i < 2; i++) begin
			cm_n[i] = rise[GATE_MODE_A + i] ? cycle3(cm_q[i]) : cm_q[i];
			span_n[i] = rise[GATE_SPAN_A + i] ? cycle3(span_q[i]) : span_q[i];
		end
		for (int i = 0; i < 2; i++) begin
			fire[i] = (rise[GATE_GLOBAL] && !cm_n[i][0])
				|| (rise[GATE_LOCAL_A + i] && cm_n[i] != CLK_GLOBAL);
			jump[i] = (pos[i][2:0] == 3'd7 || leap_n) && ({1'b0, rnd_s1[i]} < chance_s1);
			if (fire[i] && run_n && hold == 16'd0)
				pos[i] = {pos[i][3] ^ jump[i], pos[i][2:0] + 3'd1};
		end
		if (opt_q[OPT_COPY])
			pos[1] = pos[0];
		prev_n = lv_s1;
		if (rise[GATE_RESET]) begin
			pos[0] = 4'd0;
			pos[1] = 4'd0;
			hold = holdoff_ticks_q;
			prev_n[GATE_GLOBAL] = 1'b1;
		end
		hold_n = (hold != 16'd0) ? hold - 16'd1 : hold;
		for (int i = 0; i < 2; i++) begin
			kidx[i] = KNOB_MAP[i][pos[i]];
			slot[i] = bank_q[kidx[i][3:2]][{kidx[i][1:0], 4'b0} +: 16];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv_s1) begin
			v_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && adv_s1) begin
			lv_s1 <= gate_levels;
			chance_s1 <= jump_chance;
			rnd_s1[0] <= random_a;
			rnd_s1[1] <= random_b;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			run_q <= 1'b0;
			leap_q <= 1'b0;
			hold_q <= HOLDOFF_RESET;
			prev_q <= '1;
			for (int i = 0; i < 2; i++) begin
				pos_q[i] <= 4'd0;
				cm_q[i] <= CLK_GLOBAL;
				span_q[i] <= SPAN_RESET;
			end
		end else if (adv_s2) begin
			v_s2 <= v_s1;
			if (v_s1) begin
				run_q <= run_n;
				leap_q <= leap_n;
				hold_q <= hold_n;
				prev_q <= prev_n;
				pos_q <= pos;
				cm_q <= cm_n;
				span_q <= span_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (v_s1 && adv_s2) begin
			for (int i = 0; i < 2; i++) begin
				k_s2[i] <= slot[i][KNOB_BITS-1:0];
				ctl_s2[i].span <= span_n[i];
				ctl_s2[i].quant <= opt_q[OPT_QUANT];
			end
			pos_s2 <= pos;
			cm_s2 <= cm_n;
			run_s2 <= run_n;
			leap_s2 <= leap_n;
		end
	end

	for (genvar g = 0; g < 2; g++) begin : g_volt
		doss_volt #(
			.KNOB_BITS(KNOB_BITS)
		) u_volt (
			.knob(k_s2[g]),
			.ctl(ctl_s2[g]),
			.voltage(volt[g])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (adv_out) begin
			res_valid_q <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s2 && adv_out) begin
			volt_q <= volt;
			pos_out_q <= pos_s2;
			cm_out_q <= cm_s2;
			span_out_q[0] <= ctl_s2[0].span;
			span_out_q[1] <= ctl_s2[1].span;
			run_out_q <= run_s2;
			leap_out_q <= leap_s2;
		end
	end

	assign result_valid = res_valid_q;
	assign voltage_a = volt_q[0];
	assign voltage_b = volt_q[1];
	assign position_a = pos_out_q[0];
	assign position_b = pos_out_q[1];
	assign run_state = run_out_q;
	assign leap_state = leap_out_q;
	assign clock_mode_a = cm_out_q[0];
	assign clock_mode_b = cm_out_q[1];
	assign octave_span_a = span_out_q[0];
	assign octave_span_b = span_out_q[1];

endmodule

`default_nettype wire

### hdl/doss_check.sv
// doss_check: port-level checks of the dual orbit step sequencer core
// bound to dual_orbit_step_sequencer_core; no package dependency
`default_nettype none

module doss_check (
	input wire              clk,
	input wire              arst_n,
	input wire              item_ready,
	input wire              result_valid,
	input wire              result_ready,
	input wire signed [18:0] voltage_a,
	input wire [1:0]        clock_mode_a,
	input wire [1:0]        clock_mode_b,
	input wire [1:0]        octave_span_a,
	input wire [1:0]        octave_span_b
);

	// a waiting result keeps its value
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(voltage_a))
		else $error("result changed while stalled");

	// an empty output stage lets the whole pipe take a request
	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!result_valid |-> item_ready)
		else $error("request refused with empty output");

	// mode and span counters wrap at two
	a_mode_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> clock_mode_a != 2'd3 && clock_mode_b != 2'd3
			&& octave_span_a != 2'd3 && octave_span_b != 2'd3)
		else $error("mode or span out of range");

	// reset held at an edge leaves no result behind
	a_reset_idle: assert property (@(posedge clk)
		!arst_n |=> !result_valid)
		else $error("result valid during reset");

endmodule

bind dual_orbit_step_sequencer_core doss_check u_doss_check (.*);

`default_nettype wire

### sim/testbench.sv
`timescale 1ns / 1ps
// testbench: self-checking bench for dual_orbit_step_sequencer_core, built on an in-order
// predictor of the run/leap toggles, step rings, jump tests and voltage scaling
// depends on doss_pkg and the core; drives requests and configuration, checks every result

module testbench;
	import doss_pkg::*;

	localparam int KNOB_BITS = 12;
	localparam logic [2:0] REG_SPARE_LO = REG_OPTIONS + 3'd1;
	localparam logic [2:0] REG_SPARE_HI = REG_OPTIONS + 3'd2;
	localparam int LATENCY_PAD = 8;

	localparam logic [9:0] DIRECTED_LEVELS [24] = '{
		10'h3FF, 10'h000, 10'h001, 10'h041, 10'h001, 10'h003, 10'h043, 10'h003,
		10'h043, 10'h003, 10'h00F, 10'h003, 10'h183, 10'h003, 10'h033, 10'h003,
		10'h033, 10'h00F, 10'h1C3, 10'h243, 10'h043, 10'h002, 10'h003, 10'h043
	};

	typedef struct packed {
		logic [9:0]  levels;
		logic [16:0] chance;
		logic [15:0] rnd_a;
		logic [15:0] rnd_b;
	} tick_t;

	typedef struct packed {
		logic [18:0] volt_a;
		logic [18:0] volt_b;
		logic [3:0]  pos_a;
		logic [3:0]  pos_b;
		logic        run;
		logic        leap;
		logic [1:0]  mode_a;
		logic [1:0]  mode_b;
		logic [1:0]  span_a;
		logic [1:0]  span_b;
	} step_out_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_write = 1'b0;
	logic [2:0]  cfg_index = '0;
	logic [63:0] cfg_data = '0;
	logic        item_valid = 1'b0;
	logic        item_ready;
	logic [9:0]  gate_levels = '0;
	logic [16:0] jump_chance = '0;
	logic [15:0] random_a = '0;
	logic [15:0] random_b = '0;
	logic        result_valid;
	logic        result_ready = 1'b0;
	logic signed [18:0] voltage_a;
	logic signed [18:0] voltage_b;
	logic [3:0]  position_a;
	logic [3:0]  position_b;
	logic        run_state;
	logic        leap_state;
	logic [1:0]  clock_mode_a;
	logic [1:0]  clock_mode_b;
	logic [1:0]  octave_span_a;
	logic [1:0]  octave_span_b;

	// predictor state
	logic [63:0] knob_bank [4];
	logic [15:0] holdoff_ticks;
	logic [2:0]  option_bits;
	logic        run_flag;
	logic        leap_flag;
	logic [3:0]  step_pos [2];
	logic [1:0]  clk_mode [2];
	logic [1:0]  span_sel [2];
	logic [15:0] holdoff_count;
	logic [9:0]  prev_levels;

	tick_t     tick_queue [$];
	step_out_t predicted_outputs [$];
	tick_t     next_tick;
	step_out_t got_out;
	step_out_t want_out;
	int        mismatch_count = 0;
	int        send_idle_pct = 0;
	int        recv_stall_pct = 0;
	logic [9:0] stim_levels;

	dual_orbit_step_sequencer_core #(
		.KNOB_BITS(KNOB_BITS)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.gate_levels(gate_levels),
		.jump_chance(jump_chance),
		.random_a(random_a),
		.random_b(random_b),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.voltage_a(voltage_a),
		.voltage_b(voltage_b),
		.position_a(position_a),
		.position_b(position_b),
		.run_state(run_state),
		.leap_state(leap_state),
		.clock_mode_a(clock_mode_a),
		.clock_mode_b(clock_mode_b),
		.octave_span_a(octave_span_a),
		.octave_span_b(octave_span_b)
	);

	always #5 clk = ~clk;

	function automatic logic [18:0] knob_voltage(input logic [3:0] knob, input logic [1:0] span);
		logic [63:0] bank;
		longint k, den, mul, r, s, semis, v;
		bank = knob_bank[knob[3:2]];
		k = longint'((bank >> (16 * knob[1:0])) & ((64'd1 << KNOB_BITS) - 64'd1));
		den = longint'(1) << KNOB_BITS;
		r = longint'(span);
		mul = 2 * r + 1;
		if (option_bits[OPT_QUANT]) begin
			s = k * mul * 12 - 12 * r * den;
			if (s >= 0)
				semis = (s + den / 2) / den;
			else
				semis = -((-s + den / 2) / den);
			v = semis * 4096;
		end else begin
			v = (k * mul * 49152) / den - r * 49152;
		end
		return v[18:0];
	endfunction

	task automatic predict_tick(input tick_t t);
		logic [9:0]  rise;
		logic        ring;
		logic [2:0]  s8;
		logic        g, l;
		logic [15:0] rnd;
		step_out_t   o;
		rise = t.levels & ~prev_levels;
		prev_levels = t.levels;
		if (rise[GATE_RUN]) begin
			run_flag = ~run_flag;
			if (run_flag) begin
				holdoff_count = holdoff_ticks;
				if (option_bits[OPT_RUN_RESET]) begin
					step_pos[0] = '0;
					step_pos[1] = '0;
				end
			end
		end
		if (rise[GATE_LEAP])
			leap_flag = ~leap_flag;
		for (int i = 0; i < 2; i++) begin
			if (rise[GATE_MODE_A + i])
				clk_mode[i] = (clk_mode[i] >= CLK_BOTH) ? CLK_GLOBAL : clk_mode[i] + 2'd1;
			if (rise[GATE_SPAN_A + i])
				span_sel[i] = (span_sel[i] >= 2'd2) ? 2'd0 : span_sel[i] + 2'd1;
		end
		for (int i = 0; i < 2; i++) begin
			g = rise[GATE_GLOBAL] && !clk_mode[i][0];
			l = rise[GATE_LOCAL_A + i] && (clk_mode[i] >= CLK_LOCAL);
			rnd = (i == 0) ? t.rnd_a : t.rnd_b;
			if ((g || l) && run_flag && holdoff_count == 0) begin
				ring = step_pos[i][3];
				s8 = step_pos[i][2:0];
				if ((s8 == 3'd7 || leap_flag) && {1'b0, rnd} < t.chance)
					ring = ~ring;
				s8 = s8 + 3'd1;
				step_pos[i] = {ring, s8};
			end
		end
		if (option_bits[OPT_COPY])
			step_pos[1] = step_pos[0];
		if (rise[GATE_RESET]) begin
			step_pos[0] = '0;
			step_pos[1] = '0;
			holdoff_count = holdoff_ticks;
			prev_levels[GATE_GLOBAL] = 1'b1;
		end
		o.volt_a = knob_voltage(KNOB_MAP[0][step_pos[0]], span_sel[0]);
		o.volt_b = knob_voltage(KNOB_MAP[1][step_pos[1]], span_sel[1]);
		o.pos_a = step_pos[0];
		o.pos_b = step_pos[1];
		o.run = run_flag;
		o.leap = leap_flag;
		o.mode_a = clk_mode[0];
		o.mode_b = clk_mode[1];
		o.span_a = span_sel[0];
		o.span_b = span_sel[1];
		predicted_outputs.push_back(o);
		if (holdoff_count != 0)
			holdoff_count = holdoff_count - 16'd1;
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
		@(posedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			REG_KNOB_0, REG_KNOB_1, REG_KNOB_2, REG_KNOB_3: knob_bank[idx[1:0]] = val;
			REG_HOLDOFF: holdoff_ticks = val[15:0];
			REG_OPTIONS: option_bits = val[2:0];
			default: ;
		endcase
		@(posedge clk);
		cfg_write <= 1'b0;
	endtask

	task automatic queue_tick(input logic [9:0] lv, input logic [16:0] ch,
			input logic [15:0] ra, input logic [15:0] rb);
		tick_t t;
		t.levels = lv;
		t.chance = ch;
		t.rnd_a = ra;
		t.rnd_b = rb;
		tick_queue.push_back(t);
	endtask

	task automatic drain();
		do
			@(posedge clk);
		while (tick_queue.size() != 0 || item_valid || predicted_outputs.size() != 0);
		repeat (LATENCY_PAD) @(posedge clk);
	endtask

	function automatic logic [16:0] random_chance();
		case ($urandom_range(7))
			0: return 17'd0;
			1: return 17'd65536;
			2: return 17'($urandom_range(131071, 65536));
			default: return 17'($urandom_range(65535));
		endcase
	endfunction

	// request driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid <= 1'b0;
			gate_levels <= '0;
			jump_chance <= '0;
			random_a <= '0;
			random_b <= '0;
		end else if (!item_valid || item_ready) begin
			if (item_valid)
				predict_tick('{gate_levels, jump_chance, random_a, random_b});
			if (tick_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				next_tick = tick_queue.pop_front();
				item_valid <= 1'b1;
				gate_levels <= next_tick.levels;
				jump_chance <= next_tick.chance;
				random_a <= next_tick.rnd_a;
				random_b <= next_tick.rnd_b;
			end else begin
				item_valid <= 1'b0;
			end
		end
	end

	// result monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_ready <= 1'b0;
		end else begin
			if (result_valid && result_ready) begin
				got_out = '{voltage_a, voltage_b, position_a, position_b, run_state, leap_state,
					clock_mode_a, clock_mode_b, octave_span_a, octave_span_b};
				if (predicted_outputs.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("tb: result with nothing expected va=%0d vb=%0d pa=%0d pb=%0d",
							$signed(got_out.volt_a), $signed(got_out.volt_b),
							got_out.pos_a, got_out.pos_b);
				end else begin
					want_out = predicted_outputs.pop_front();
					if (got_out !== want_out) begin
						mismatch_count++;
						if (mismatch_count <= 10) begin
							$display("tb: mismatch exp va=%0d vb=%0d pa=%0d pb=%0d run=%0d leap=%0d ma=%0d mb=%0d sa=%0d sb=%0d",
								$signed(want_out.volt_a), $signed(want_out.volt_b),
								want_out.pos_a, want_out.pos_b, want_out.run, want_out.leap,
								want_out.mode_a, want_out.mode_b, want_out.span_a, want_out.span_b);
							$display("tb:          got va=%0d vb=%0d pa=%0d pb=%0d run=%0d leap=%0d ma=%0d mb=%0d sa=%0d sb=%0d",
								$signed(got_out.volt_a), $signed(got_out.volt_b),
								got_out.pos_a, got_out.pos_b, got_out.run, got_out.leap,
								got_out.mode_a, got_out.mode_b, got_out.span_a, got_out.span_b);
						end
					end
				end
			end
			result_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	initial begin
		#2_000_000;
		$display("tb: failure");
		$finish;
	end

	initial begin
		logic [15:0] hold_val;
		int odds;
		for (int i = 0; i < 4; i++)
			knob_bank[i] = '0;
		holdoff_ticks = HOLDOFF_RESET;
		option_bits = OPTIONS_RESET;
		run_flag = 1'b0;
		leap_flag = 1'b0;
		for (int i = 0; i < 2; i++) begin
			step_pos[i] = '0;
			clk_mode[i] = CLK_GLOBAL;
			span_sel[i] = SPAN_RESET;
		end
		holdoff_count = HOLDOFF_RESET;
		prev_levels = '1;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// directed: knob masking, edges, jumps, modes, spans, reset rearm
		write_reg(REG_KNOB_0, 64'hFFFF_F800_0001_0000);
		write_reg(REG_KNOB_1, {$urandom, $urandom});
		write_reg(REG_KNOB_2, {$urandom, $urandom});
		write_reg(REG_KNOB_3, '1);
		write_reg(REG_HOLDOFF, '0);
		write_reg(REG_OPTIONS, '0);
		write_reg(REG_SPARE_LO, {$urandom, $urandom});
		write_reg(REG_SPARE_HI, {$urandom, $urandom});
		for (int n = 0; n < 24; n++) begin
			if (n == 6)
				queue_tick(DIRECTED_LEVELS[n], 17'd65535, 16'd0, 16'hFFFF);
			else if (n == 8)
				queue_tick(DIRECTED_LEVELS[n], 17'd65536, 16'hFFFF, 16'hFFFF);
			else
				queue_tick(DIRECTED_LEVELS[n], random_chance(), 16'($urandom), 16'($urandom));
		end
		stim_levels = DIRECTED_LEVELS[23];
		drain();

		for (int p = 0; p < 8; p++) begin
			for (int b = 0; b < 4; b++) begin
				if (p == 1)
					write_reg(REG_KNOB_0 + 3'(b), '0);
				else if (p == 2)
					write_reg(REG_KNOB_0 + 3'(b), '1);
				else
					write_reg(REG_KNOB_0 + 3'(b), {$urandom, $urandom});
			end
			case (p)
				0, 4: hold_val = 16'd0;
				2: hold_val = 16'hFFFF;
				5: hold_val = 16'd1;
				default: hold_val = 16'($urandom_range(40));
			endcase
			write_reg(REG_HOLDOFF, {48'($urandom), hold_val});
			write_reg(REG_OPTIONS, {61'({$urandom, $urandom}), 3'(p)});
			case (p % 4)
				0: begin send_idle_pct = 0; recv_stall_pct = 0; end
				1: begin send_idle_pct = 87; recv_stall_pct = 0; end
				2: begin send_idle_pct = 0; recv_stall_pct = 87; end
				default: begin send_idle_pct = 17; recv_stall_pct = 17; end
			endcase
			for (int n = 0; n < 90; n++) begin
				if ($urandom_range(9) == 0) begin
					stim_levels = 10'($urandom);
				end else begin
					for (int b = 0; b < GATE_W; b++) begin
						odds = (b >= GATE_GLOBAL && b < GATE_RESET) ? 2 :
							(b == GATE_RUN) ? 40 : (b == GATE_RESET) ? 60 :
							(b == GATE_LEAP) ? 20 : 12;
						if ($urandom_range(odds - 1) == 0)
							stim_levels[b] = ~stim_levels[b];
					end
				end
				queue_tick(stim_levels, random_chance(), 16'($urandom), 16'($urandom));
			end
			drain();
		end

		if (mismatch_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
